@@ src/lsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Light scissor rectangle package
// Shared types and constants for the light scissor rectangle block.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int CoordWidth = 24;
    localparam int CoefWidth  = 24;
    localparam int RangeWidth = 23;
    localparam int PixWidth   = 13;
    localparam int CornWidth  = 25;
    localparam int ClipWidth  = 52;

    // Coefficients are Q8.16. Clip values are exact sums of products, so the
    // fraction count sets no datapath width and serves as documentation.
    localparam int CoefFracBits = 16;

    localparam logic [0:0] CmdLoad = 1'b0;
    localparam logic [0:0] CmdRect = 1'b1;

    localparam logic [0:0] RegScreenWidth  = 1'b0;
    localparam logic [0:0] RegScreenHeight = 1'b1;

    typedef struct packed {
        logic [0:0]                    cmd;
        logic [3:0]                    coef_index;
        logic signed [CoefWidth-1:0]   coef_value;
        logic signed [CoordWidth-1:0]  pos_x;
        logic signed [CoordWidth-1:0]  pos_y;
        logic signed [CoordWidth-1:0]  pos_z;
        logic [RangeWidth-1:0]         light_range;
    } in_item_t;

    typedef struct packed {
        logic [PixWidth-1:0] rect_left;
        logic [PixWidth-1:0] rect_top;
        logic [PixWidth-1:0] rect_right;
        logic [PixWidth-1:0] rect_bottom;
    } out_item_t;

    typedef struct packed {
        logic [0:0]          index;
        logic [PixWidth-1:0] data;
    } cfg_item_t;

    // Start and operands of the serial pixel divider.
    typedef struct packed {
        logic                        start;
        logic [ClipWidth:0]          num;
        logic [ClipWidth:0]          den;
        logic [PixWidth-1:0]         scale;
    } div_req_t;

endpackage

@@ src/lsr_stream_if.sv @@
// ----------------------------------------------------------------------------
// Light scissor rectangle channels
// Valid/ready interfaces for input, output and configuration channels.
// ----------------------------------------------------------------------------
interface lsr_in_if;
    logic             valid;
    logic             ready;
    lsr_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsr_out_if;
    logic               valid;
    logic               ready;
    lsr_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsr_cfg_if;
    logic               valid;
    logic               ready;
    lsr_pkg::cfg_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/light_scissor_rect_unit.sv @@
// ----------------------------------------------------------------------------
// Light scissor rectangle unit
// Screen-space scissor rectangle of a point light's bounding cube.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  in_ch     sink       cmd, coef_index, coef_value, pos_x/y/z, light_range
//  out_ch    source     rect_left, rect_top, rect_right, rect_bottom
//  cfg_ch    sink       register index, write data (screen width, height)
//
// A load item is written on acceptance and leaves the block idle. A rect item
// walks the eight cube corners; per corner the shared multiplier runs twelve
// products (three clip columns of four terms, each followed by a drain) and
// the shared serial divider two 13-step divisions. Most of an item's time is
// spent in the divider.
// Reset clears the coefficient file to zero and the screen size to
// 1920 by 1080. A stalled result holds in the output register; the next item
// is accepted while it waits, but the following result waits for it.
module light_scissor_rect_unit (
    input  logic         clk,
    input  logic         rst_n,
    lsr_in_if.sink       in_ch,
    lsr_out_if.source    out_ch,
    lsr_cfg_if.sink      cfg_ch
);
    import lsr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAC   = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_DIVX  = 7'b0001000,
        ST_DIVY  = 7'b0010000,
        ST_NEXT  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CoefWidth-1:0]         coef_reg [16];
    logic [15:0]                  coef_vld_reg;
    logic [PixWidth-1:0]          width_reg, height_reg;
    logic signed [CoordWidth-1:0] px_reg, py_reg, pz_reg;
    logic [RangeWidth-1:0]        r_reg;
    logic [2:0]                   corner_reg;
    logic [1:0]                   col_reg;    // 0 X, 1 Y, 2 W
    logic [1:0]                   term_reg;
    logic [1:0]                   drain_reg;
    logic signed [ClipWidth-1:0]  cx_reg, cy_reg;
    logic [PixWidth-1:0]          minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic                         out_vld_reg;
    out_item_t                    out_reg;
    logic                         div_started_reg;

    logic                         mac_clear, mac_en;
    logic signed [CornWidth-1:0]  op_a;
    logic signed [CoefWidth-1:0]  op_b;
    logic signed [ClipWidth-1:0]  acc;
    logic [3:0]                   coef_addr;
    logic signed [CornWidth-1:0]  rr;
    div_req_t                     div_req;
    logic                         div_busy;
    logic [PixWidth-1:0]          quot;
    logic signed [ClipWidth:0]    num_s, w_s, nclamp;
    logic                         flip;
    logic [ClipWidth:0]           div_num, div_den;

    // Items are taken only in idle; a waiting result does not block input.
    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid   = out_vld_reg;
    assign out_ch.payload = out_reg;

    // Corner operand of the current term.
    assign rr = CornWidth'(r_reg);
    always_comb
    begin
        unique case (term_reg)
            2'd0:    op_a = corner_reg[0] ? CornWidth'(px_reg) + rr : CornWidth'(px_reg) - rr;
            2'd1:    op_a = corner_reg[1] ? CornWidth'(py_reg) - rr : CornWidth'(py_reg) + rr;
            2'd2:    op_a = corner_reg[2] ? CornWidth'(pz_reg) + rr : CornWidth'(pz_reg) - rr;
            default: op_a = CornWidth'(256);
        endcase
        coef_addr = {term_reg, (col_reg == 2'd2) ? 2'd3 : col_reg};
        op_b = coef_vld_reg[coef_addr] ? coef_reg[coef_addr] : '0;
    end

    assign mac_clear = (state_reg == ST_MAC) && term_reg == 2'd0;
    assign mac_en    = (state_reg == ST_MAC);

    lsr_mac u_mac (
        .clk    (clk),
        .clear  (mac_clear),
        .enable (mac_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .acc    (acc)
    );

    // Clamp and fold the sign of w into the numerator for the divider.
    always_comb
    begin
        flip  = (state_reg == ST_DIVY);
        num_s = (ClipWidth+1)'(flip ? cy_reg : cx_reg);
        w_s   = (ClipWidth+1)'(acc);
        if (w_s == 0)
        begin
            num_s = num_s[ClipWidth] ? -(ClipWidth+1)'(1) : (ClipWidth+1)'(1);
            w_s   = (ClipWidth+1)'(1);
        end
        else if (w_s < 0)
        begin
            num_s = -num_s;
            w_s   = -w_s;
        end
        nclamp = num_s;
        if (nclamp > w_s)
            nclamp = w_s;
        if (nclamp < -w_s)
            nclamp = -w_s;
        if (flip)
            nclamp = -nclamp;
        div_num = nclamp + w_s;
        div_den = w_s <<< 1;
    end

    always_comb
    begin
        div_req.start = ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)) && !div_started_reg;
        div_req.num   = div_num;
        div_req.den   = div_den;
        div_req.scale = (state_reg == ST_DIVY) ? height_reg : width_reg;
    end

    lsr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_ch.valid && in_ch.ready && in_ch.payload.cmd == CmdRect)
                          state_next = ST_MAC;
            ST_MAC:   if (term_reg == 2'd3)
                          state_next = ST_DRAIN;
            ST_DRAIN: if (drain_reg == 2'd1)
                          state_next = (col_reg == 2'd2) ? ST_DIVX : ST_MAC;
            ST_DIVX:  if (div_started_reg && !div_busy)
                          state_next = ST_DIVY;
            ST_DIVY:  if (div_started_reg && !div_busy)
                          state_next = ST_NEXT;
            ST_NEXT:  state_next = (corner_reg == 3'd7) ? ST_OUT : ST_MAC;
            ST_OUT:   if (!out_vld_reg || out_ch.ready)
                          state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            coef_vld_reg    <= '0;
            width_reg       <= PixWidth'(1920);
            height_reg      <= PixWidth'(1080);
            out_vld_reg     <= 1'b0;
            term_reg        <= '0;
            col_reg         <= '0;
            corner_reg      <= '0;
            drain_reg       <= '0;
            div_started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid)
            begin
                if (cfg_ch.payload.index == RegScreenWidth)
                    width_reg <= cfg_ch.payload.data;
                else
                    height_reg <= cfg_ch.payload.data;
            end
            // A new result may replace the one leaving at the same edge.
            if (state_reg == ST_OUT && (!out_vld_reg || out_ch.ready))
                out_vld_reg <= 1'b1;
            else if (out_vld_reg && out_ch.ready)
                out_vld_reg <= 1'b0;
            if (in_ch.valid && in_ch.ready && in_ch.payload.cmd == CmdLoad)
                coef_vld_reg[in_ch.payload.coef_index] <= 1'b1;
            unique case (state_reg)
                ST_IDLE:
                begin
                    term_reg   <= '0;
                    col_reg    <= '0;
                    corner_reg <= '0;
                end
                ST_MAC:
                begin
                    term_reg  <= term_reg + 2'd1;
                    drain_reg <= '0;
                end
                ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 2'd1;
                    if (drain_reg == 2'd1 && col_reg != 2'd2)
                        col_reg <= col_reg + 2'd1;
                end
                ST_DIVX, ST_DIVY:
                begin
                    if (!div_started_reg)
                        div_started_reg <= 1'b1;
                    else if (!div_busy)
                        div_started_reg <= 1'b0;
                end
                ST_NEXT:
                begin
                    col_reg    <= '0;
                    corner_reg <= corner_reg + 3'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            if (in_ch.payload.cmd == CmdLoad)
                coef_reg[in_ch.payload.coef_index] <= in_ch.payload.coef_value;
            px_reg <= in_ch.payload.pos_x;
            py_reg <= in_ch.payload.pos_y;
            pz_reg <= in_ch.payload.pos_z;
            r_reg  <= in_ch.payload.light_range;
            minx_reg <= '1;
            miny_reg <= '1;
            maxx_reg <= '0;
            maxy_reg <= '0;
        end
        if (state_reg == ST_DRAIN && drain_reg == 2'd1)
        begin
            if (col_reg == 2'd0)
                cx_reg <= acc;
            if (col_reg == 2'd1)
                cy_reg <= acc;
        end
        if (state_reg == ST_DIVX && div_started_reg && !div_busy)
        begin
            if (quot < minx_reg) minx_reg <= quot;
            if (quot > maxx_reg) maxx_reg <= quot;
        end
        if (state_reg == ST_DIVY && div_started_reg && !div_busy)
        begin
            if (quot < miny_reg) miny_reg <= quot;
            if (quot > maxy_reg) maxy_reg <= quot;
        end
        if (state_reg == ST_OUT && (!out_vld_reg || out_ch.ready))
        begin
            out_reg.rect_left   <= minx_reg;
            out_reg.rect_top    <= miny_reg;
            out_reg.rect_right  <= maxx_reg;
            out_reg.rect_bottom <= maxy_reg;
        end
    end
endmodule

@@ src/lsr_divider.sv @@
// ----------------------------------------------------------------------------
// Light scissor rectangle pixel divider
// Serial multiply-divide: floor(num * scale / den), one scale bit a cycle.
// ----------------------------------------------------------------------------
module lsr_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lsr_pkg::div_req_t         req,
    output logic                      busy,
    output logic [lsr_pkg::PixWidth-1:0] quot
);
    import lsr_pkg::*;

    localparam int RemWidth = ClipWidth + 2;

    logic [RemWidth-1:0]  rem_reg, rem_next;
    logic [ClipWidth:0]   num_reg, den_reg;
    logic [PixWidth-1:0]  scale_reg, q_reg, q_next;
    logic [3:0]           bit_reg;
    logic                 busy_reg;
    logic [RemWidth-1:0]  acc, sub1, sub2;
    logic [1:0]           qinc;

    // With num <= den the partial remainder stays below 3*den, so at most
    // two subtractions are needed in a step.
    always_comb
    begin
        acc = {rem_reg[RemWidth-2:0], 1'b0}
            + (scale_reg[bit_reg] ? {1'b0, num_reg} : '0);
        sub1 = acc;
        qinc = 2'd0;
        if (sub1 >= {1'b0, den_reg})
        begin
            sub1 = sub1 - {1'b0, den_reg};
            qinc = 2'd1;
        end
        sub2 = sub1;
        if (sub2 >= {1'b0, den_reg})
        begin
            sub2 = sub2 - {1'b0, den_reg};
            qinc = 2'd2;
        end
        rem_next = sub2;
        q_next = {q_reg[PixWidth-2:0], 1'b0} + {{(PixWidth-2){1'b0}}, qinc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= 4'(PixWidth - 1);
        end
        else if (busy_reg)
        begin
            if (bit_reg == 4'd0)
                busy_reg <= 1'b0;
            else
                bit_reg <= bit_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg   <= '0;
            q_reg     <= '0;
            num_reg   <= req.num;
            den_reg   <= req.den;
            scale_reg <= req.scale;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule

@@ src/lsr_mac.sv @@
// ----------------------------------------------------------------------------
// Light scissor rectangle multiply-accumulate
// One shared signed 25x24 multiplier with a 52-bit accumulator.
// ----------------------------------------------------------------------------
module lsr_mac (
    input  logic                                 clk,
    input  logic                                 clear,
    input  logic                                 enable,
    input  logic signed [lsr_pkg::CornWidth-1:0] op_a,
    input  logic signed [lsr_pkg::CoefWidth-1:0] op_b,
    output logic signed [lsr_pkg::ClipWidth-1:0] acc
);
    import lsr_pkg::*;

    logic signed [CornWidth+CoefWidth-1:0] prod_reg;
    logic                                  prod_vld_reg;
    logic signed [ClipWidth-1:0]           acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg     <= op_a * op_b;
        prod_vld_reg <= enable;
        if (clear)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ClipWidth'(prod_reg);
    end

    assign acc = acc_reg;
endmodule

@@ test/light_scissor_rect_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Light scissor rectangle unit testbench
// Drives matrix loads and light items through the valid/ready channels,
// predicts every scissor rectangle in step with the accepted items and
// checks each result field by field, across several screen sizes and
// idling patterns.
// ----------------------------------------------------------------------------
module light_scissor_rect_unit_tb;

    import lsr_pkg::*;

    // The settle wait covers a rect item with margin.
    localparam int SettleCycles = 600;
    localparam int RandomItems  = 1450;
    localparam int PhaseCount   = 8;

    logic clk;
    logic rst_n;

    lsr_in_if  in_ch ();
    lsr_out_if out_ch ();
    lsr_cfg_if cfg_ch ();

    light_scissor_rect_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Items waiting to be offered and rectangles waiting to come back.
    in_item_t  pending_items[$];
    out_item_t expected_rects[$];

    // Own copy of the block's state, updated on accepted items and writes.
    longint       coef_file[16];
    logic [12:0]  scr_width;
    logic [12:0]  scr_height;

    // Idling pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
    int  idle_mode;
    bit  in_took;
    bit  failed;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Pixel coordinate of numerator over w scaled by s, truncated. The
    // division is done as a serial multiply-divide, exactly like the
    // block's fixed point definition, so no rounding enters but the last.
    function automatic logic [12:0] corner_pixel(longint num, longint w,
                                                 logic [12:0] s, bit flip);
        longint unsigned a;
        longint unsigned d;
        longint unsigned rem;
        int q;
        if (w == 0)
        begin
            // Zero w saturates to an edge by the numerator's sign.
            num = (num >= 0) ? 1 : -1;
            w = 1;
        end
        else if (w < 0)
        begin
            num = -num;
            w = -w;
        end
        if (num > w)
            num = w;
        if (num < -w)
            num = -w;
        if (flip)
            num = -num;
        a = num + w;
        d = 2 * w;
        rem = 0;
        q = 0;
        for (int b = 12; b >= 0; b--)
        begin
            rem = rem << 1;
            q = q << 1;
            if (s[b])
                rem = rem + a;
            while (rem >= d)
            begin
                rem = rem - d;
                q++;
            end
        end
        return q[12:0];
    endfunction

    // Bounding rectangle of the eight projected cube corners.
    function automatic out_item_t light_rect(in_item_t it);
        longint px;
        longint py;
        longint pz;
        longint r;
        longint v[4];
        longint clip[4];
        logic [12:0] x;
        logic [12:0] y;
        out_item_t res;
        px = longint'(it.pos_x);
        py = longint'(it.pos_y);
        pz = longint'(it.pos_z);
        r = longint'({1'b0, it.light_range});
        res.rect_left = 13'h1FFF;
        res.rect_top = 13'h1FFF;
        res.rect_right = 13'h0;
        res.rect_bottom = 13'h0;
        for (int k = 0; k < 8; k++)
        begin
            v[0] = k[0] ? px + r : px - r;
            v[1] = k[1] ? py - r : py + r;
            v[2] = k[2] ? pz + r : pz - r;
            v[3] = 256;
            for (int j = 0; j < 4; j++)
                clip[j] = v[0] * coef_file[j] + v[1] * coef_file[4 + j]
                        + v[2] * coef_file[8 + j] + v[3] * coef_file[12 + j];
            x = corner_pixel(clip[0], clip[3], scr_width, 1'b0);
            y = corner_pixel(clip[1], clip[3], scr_height, 1'b1);
            if (x < res.rect_left)   res.rect_left = x;
            if (x > res.rect_right)  res.rect_right = x;
            if (y < res.rect_top)    res.rect_top = y;
            if (y > res.rect_bottom) res.rect_bottom = y;
        end
        return res;
    endfunction

    // Random 24-bit value whose magnitude is spread over all scales, with
    // an occasional extreme.
    function automatic logic [23:0] spread24();
        int v;
        v = $urandom;
        case ($urandom_range(0, 19))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h0;
            default: return 24'(v >>> $urandom_range(0, 23));
        endcase
    endfunction

    function automatic in_item_t load_item(int idx, logic [23:0] val);
        in_item_t it;
        // Position and range are ignored on a load; fill them with noise.
        it.cmd = CmdLoad;
        it.coef_index = idx[3:0];
        it.coef_value = val;
        it.pos_x = 24'($urandom);
        it.pos_y = 24'($urandom);
        it.pos_z = 24'($urandom);
        it.light_range = 23'($urandom);
        return it;
    endfunction

    function automatic in_item_t rect_item(logic [23:0] x, logic [23:0] y,
                                           logic [23:0] z, logic [22:0] r);
        in_item_t it;
        it.cmd = CmdRect;
        it.coef_index = 4'($urandom);
        it.coef_value = 24'($urandom);
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.light_range = r;
        return it;
    endfunction

    // Driver: offers the next pending item at the falling edge, holding it
    // until it is taken. The sender idles between items when asked to.
    always @(negedge clk)
    begin
        logic nv;
        int idle_pct;
        // With both sides idling each idles a quarter of the time.
        idle_pct = (idle_mode == 3) ? 25 : 49;
        nv = in_ch.valid && !in_took;
        if (rst_n && !nv && pending_items.size() > 0 &&
            !(idle_mode[0] && $urandom_range(0, 99) < idle_pct))
        begin
            in_ch.payload <= pending_items.pop_front();
            nv = 1'b1;
        end
        in_ch.valid <= nv;
        out_ch.ready <= rst_n && !(idle_mode[1] && $urandom_range(0, 99) < idle_pct);
    end

    // Monitor: checks results against the oldest expectation, then runs
    // the predictor on the item accepted at the same edge.
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        in_took <= in_ch.valid && in_ch.ready;
        if (out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (expected_rects.size() == 0)
            begin
                $display("%0t: unexpected rectangle %p", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_rects.pop_front();
                if (got.rect_left !== want.rect_left)
                begin
                    $display("%0t: rect_left expected %0d actual %0d",
                             $time, want.rect_left, got.rect_left);
                    failed = 1'b1;
                end
                if (got.rect_top !== want.rect_top)
                begin
                    $display("%0t: rect_top expected %0d actual %0d",
                             $time, want.rect_top, got.rect_top);
                    failed = 1'b1;
                end
                if (got.rect_right !== want.rect_right)
                begin
                    $display("%0t: rect_right expected %0d actual %0d",
                             $time, want.rect_right, got.rect_right);
                    failed = 1'b1;
                end
                if (got.rect_bottom !== want.rect_bottom)
                begin
                    $display("%0t: rect_bottom expected %0d actual %0d",
                             $time, want.rect_bottom, got.rect_bottom);
                    failed = 1'b1;
                end
            end
        end
        if (in_ch.valid && in_ch.ready)
        begin
            if (in_ch.payload.cmd == CmdLoad)
                coef_file[in_ch.payload.coef_index] =
                    longint'(in_ch.payload.coef_value);
            else
                expected_rects.push_back(light_rect(in_ch.payload));
        end
    end

    // Register write on the configuration channel; the predictor follows
    // the write at the edge where it is taken.
    task automatic write_reg(logic [0:0] idx, logic [12:0] data);
        @(negedge clk);
        cfg_ch.payload.index <= idx;
        cfg_ch.payload.data <= data;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == RegScreenWidth)
            scr_width = data;
        else
            scr_height = data;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed opening: zero matrix, simple scaling, extreme coordinates,
    // zero w with both numerator signs, negative w and extreme coefficients.
    task automatic queue_directed();
        pending_items.push_back(rect_item(24'h7FFFFF, 24'h800000, 24'h0,
                                          23'h7FFFFF));
        pending_items.push_back(load_item(0, 24'd65536));
        pending_items.push_back(load_item(5, 24'd65536));
        pending_items.push_back(load_item(10, 24'd65536));
        pending_items.push_back(load_item(15, 24'd65536));
        pending_items.push_back(rect_item(24'h0, 24'h0, 24'h0, 23'h0));
        pending_items.push_back(rect_item(24'd64, 24'hFFFFC0, 24'd10, 23'd32));
        pending_items.push_back(rect_item(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                          23'h7FFFFF));
        pending_items.push_back(rect_item(24'h800000, 24'h800000, 24'h800000,
                                          23'h0));
        // Zero w: negative x numerator goes to the left edge, zero to the right.
        pending_items.push_back(load_item(15, 24'h0));
        pending_items.push_back(rect_item(24'hFFFF00, 24'd0, 24'd0, 23'd0));
        pending_items.push_back(rect_item(24'd0, 24'd0, 24'd0, 23'd0));
        pending_items.push_back(rect_item(24'd512, 24'hFFFE00, 24'd0, 23'd128));
        pending_items.push_back(load_item(15, 24'hFF0000));
        pending_items.push_back(rect_item(24'd300, 24'd100, 24'd5, 23'd50));
        pending_items.push_back(load_item(0, 24'h800000));
        pending_items.push_back(load_item(4, 24'h7FFFFF));
        pending_items.push_back(load_item(11, 24'h7FFFFF));
        pending_items.push_back(rect_item(24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                          23'h7FFFFF));
        pending_items.push_back(rect_item(24'h123456, 24'hABCDEF, 24'h0F0F0F,
                                          23'h2AAAAA));
    endtask

    // Random part: mostly a full matrix load followed by a run of lights,
    // usually a camera-like matrix so rectangles fall inside the screen,
    // and now and then loose noise items.
    task automatic queue_random(int count);
        int n;
        int order[16];
        bit camera;
        logic [23:0] m[16];
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 1))
                        pending_items.push_back(load_item($urandom_range(0, 15),
                                                          24'($urandom)));
                    else
                        pending_items.push_back(rect_item(24'($urandom),
                            24'($urandom), 24'($urandom), 23'($urandom)));
                    n++;
                end
            end
            else
            begin
                camera = $urandom_range(0, 9) < 7;
                for (int i = 0; i < 16; i++)
                begin
                    m[i] = camera ? 24'(int'($urandom) >>> $urandom_range(16, 31))
                                  : spread24();
                    order[i] = i;
                end
                if (camera)
                begin
                    m[0] = 24'($urandom_range(8000, 200000));
                    m[5] = 24'($urandom_range(8000, 200000));
                    m[10] = 24'($urandom_range(60000, 70000));
                    m[11] = 24'd65536;
                    m[14] = 24'(-int'($urandom_range(0, 1 << 20)));
                    m[15] = 24'h0;
                end
                order.shuffle();
                for (int i = 0; i < 16; i++)
                    pending_items.push_back(load_item(order[i], m[order[i]]));
                n += 16;
                repeat ($urandom_range(4, 12))
                begin
                    if (camera && $urandom_range(0, 3) != 0)
                        pending_items.push_back(rect_item(
                            24'(int'($urandom_range(0, 1 << 17)) - (1 << 16)),
                            24'(int'($urandom_range(0, 1 << 17)) - (1 << 16)),
                            24'(int'($urandom_range(0, 1 << 18)) - (1 << 12)),
                            23'($urandom_range(0, 1 << 15))));
                    else
                        pending_items.push_back(rect_item(spread24(),
                            spread24(), spread24(), 23'(spread24())));
                    n++;
                end
            end
        end
    endtask

    // Waits until every item is taken and every rectangle has come back,
    // then lets the block finish any load still in flight.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid ||
               expected_rects.size() > 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    initial
    begin
        logic [12:0] widths[PhaseCount];
        logic [12:0] heights[PhaseCount];
        failed = 1'b0;
        in_took = 1'b0;
        idle_mode = 0;
        scr_width = 13'd1920;
        scr_height = 13'd1080;
        for (int i = 0; i < 16; i++)
            coef_file[i] = 0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        rst_n = 1'b0;
        // Screen sizes per phase; the first keeps the reset size.
        widths = '{13'd1920, 13'd4096, 13'd1, 13'd0, 13'd8191, 13'd640,
                   13'd0, 13'd0};
        heights = '{13'd1080, 13'd4096, 13'd1, 13'd8191, 13'd0, 13'd480,
                    13'd0, 13'd0};
        widths[6] = 13'($urandom_range(1, 4096));
        heights[6] = 13'($urandom_range(1, 4096));
        widths[7] = 13'($urandom);
        heights[7] = 13'($urandom);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PhaseCount; p++)
        begin
            if (p > 0)
            begin
                write_reg(RegScreenWidth, widths[p]);
                write_reg(RegScreenHeight, heights[p]);
            end
            idle_mode = (p == 0) ? 0 : p % 4;
            if (p == 0)
                queue_directed();
            queue_random(RandomItems / PhaseCount);
            drain();
        end
        if (!failed)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

endmodule
